// ===== rtl/assert_macros.svh =====
// Assertion helpers: both forms sample on clk and are disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check in the same cycle
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check in the following cycle
`define BBA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BBA_ASSERT_IMP(lbl, ante, cons, msg)
`define BBA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/bba_pkg.sv =====
package bba_pkg;

	// Bitmap size and field widths
	localparam int unsigned MAX_BLOCKS = 64;
	localparam int unsigned IDX_W      = 6;
	localparam int unsigned LEN_W      = 7;
	localparam int unsigned CNT_W      = 7;
	localparam int unsigned PADDR_W    = 3;
	localparam int unsigned PDATA_W    = 32;

	// Register map: index taken from paddr[2]
	localparam logic REG_BLOCKS_IN_USE = 1'b0;
	localparam logic [CNT_W-1:0] BLOCKS_RESET = 7'd64;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_USED    = 2'd1,
		ST_NOSPACE = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHK,
		S_SCAN,
		S_REL,
		S_RESP,
		S_ORD,
		S_OWR
	} bba_state_t;

endpackage

// ===== rtl/bba_req_if.sv =====
interface bba_req_if;
	import bba_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] first_block;
	logic [LEN_W-1:0] file_length;

	modport source (output valid, output first_block, output file_length, input ready);
	modport sink   (input valid, input first_block, input file_length, output ready);

endinterface

// ===== rtl/bba_res_if.sv =====
interface bba_res_if;
	import bba_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] block_index;
	status_t          status;
	logic             last_of_run;

	modport source (output valid, output block_index, output status, output last_of_run,
		input ready);
	modport sink   (input valid, input block_index, input status, input last_of_run,
		output ready);

endinterface

// ===== rtl/bitmap_block_allocator.sv =====
// First-fit block allocator over a used/free bitmap held in a synchronous RAM.
// After acceptance an out-of-range start goes straight to the result, a used start follows
// the bitmap check; otherwise a scan of up to n entries (n: blocks_in_use capped at 64),
// then one result per held block, or on failure a release pass over the held blocks first.
// One request at a time; the bitmap RAM (one entry a cycle) and the held-list RAM set the
// rate. Reset clears the valid bits (every block free), blocks_in_use 64.
`include "assert_macros.svh"

module bitmap_block_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	bba_req_if.sink                     req,
	bba_res_if.source                   res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bba_pkg::PADDR_W-1:0] paddr,
	input  logic [bba_pkg::PDATA_W-1:0] pwdata,
	output logic [bba_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import bba_pkg::*;

	// Configuration
	logic [CNT_W-1:0] cfg_q;
	logic [CNT_W-1:0] n_eff;

	// Control
	bba_state_t       state_q, state_d;
	logic [IDX_W-1:0] start_q;
	logic [LEN_W-1:0] want_q;
	status_t          resp_status_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;

	// Bitmap RAM with valid bits
	logic             used_mem [MAX_BLOCKS];
	logic [MAX_BLOCKS-1:0] uvld_q;
	logic             u_rdata_s1;
	logic             u_rvld_s1;
	logic             used_s1;
	logic             u_rd_en, u_wr_en, u_wr_data;
	logic [IDX_W-1:0] u_rd_addr, u_wr_addr;

	// Held-list RAM
	logic [IDX_W-1:0] held_mem [MAX_BLOCKS];
	logic [IDX_W-1:0] hdata_s1;
	logic             h_rd_en, h_wr_en;
	logic [IDX_W-1:0] h_rd_addr, h_wr_addr, h_wr_data;

	// Output register
	logic             res_valid_q;
	logic [IDX_W-1:0] res_idx_q;
	status_t          res_status_q;
	logic             res_last_q;
	logic             out_free, out_load, out_last;
	logic [IDX_W-1:0] out_idx;
	status_t          out_status;

	logic             take;
	logic             scan_rd, rel_rd;

	// APB register access
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BLOCKS_IN_USE) ?
		{{(PDATA_W-CNT_W){1'b0}}, cfg_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= BLOCKS_RESET;
		end else if (psel && penable && pwrite && pready &&
			paddr[2] == REG_BLOCKS_IN_USE) begin
			cfg_q <= pwdata[CNT_W-1:0];
		end
	end

	// Cap the count at the bitmap size
	assign n_eff   = (cfg_q > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : cfg_q;
	assign used_s1 = u_rdata_s1 & u_rvld_s1;
	assign out_free = !res_valid_q || res.ready;

	// Next state and strobes
	always_comb begin
		state_d    = state_q;
		req.ready  = 1'b0;
		u_rd_en    = 1'b0;
		u_rd_addr  = idx_q[IDX_W-1:0];
		u_wr_en    = 1'b0;
		u_wr_addr  = idx_s1;
		u_wr_data  = 1'b0;
		h_rd_en    = 1'b0;
		h_rd_addr  = idx_q[IDX_W-1:0];
		h_wr_en    = 1'b0;
		h_wr_addr  = cnt_q[IDX_W-1:0];
		h_wr_data  = idx_s1;
		out_load   = 1'b0;
		out_idx    = start_q;
		out_status = resp_status_q;
		out_last   = 1'b1;
		take       = 1'b0;
		scan_rd    = 1'b0;
		rel_rd     = 1'b0;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if ({1'b0, req.first_block} >= n_eff) begin
						state_d = S_RESP;
					end else begin
						u_rd_en   = 1'b1;
						u_rd_addr = req.first_block;
						state_d   = S_CHK;
					end
				end
			end
			S_CHK: begin
				if (used_s1) begin
					state_d = S_RESP;
				end else begin
					u_wr_en   = 1'b1;
					u_wr_addr = start_q;
					u_wr_data = 1'b1;
					h_wr_en   = 1'b1;
					h_wr_addr = '0;
					h_wr_data = start_q;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				if (cnt_q >= want_q) begin
					state_d = S_ORD;
				end else begin
					// Take the entry read last cycle if it is free
					take = vld_s1 && !used_s1;
					if (take) begin
						u_wr_en   = 1'b1;
						u_wr_data = 1'b1;
						h_wr_en   = 1'b1;
					end
					if (idx_q < n_eff) begin
						u_rd_en = 1'b1;
						scan_rd = 1'b1;
					end else if (!vld_s1) begin
						state_d = S_REL;
					end
				end
			end
			S_REL: begin
				// Free every held block again, one a cycle
				if (vld_s1) begin
					u_wr_en   = 1'b1;
					u_wr_addr = hdata_s1;
					u_wr_data = 1'b0;
				end
				if (idx_q < cnt_q) begin
					h_rd_en = 1'b1;
					rel_rd  = 1'b1;
				end else if (!vld_s1) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_ORD: begin
				h_rd_en = 1'b1;
				state_d = S_OWR;
			end
			S_OWR: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_idx    = hdata_s1;
					out_status = ST_OK;
					out_last   = (idx_q + CNT_W'(1)) == cnt_q;
					state_d    = out_last ? S_IDLE : S_ORD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Request bookkeeping and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q       <= '0;
			want_q        <= '0;
			resp_status_q <= ST_OK;
			cnt_q         <= '0;
			idx_q         <= '0;
			vld_s1        <= 1'b0;
			idx_s1        <= '0;
		end else begin
			vld_s1 <= scan_rd || rel_rd;
			idx_s1 <= idx_q[IDX_W-1:0];
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						start_q       <= req.first_block;
						want_q        <= req.file_length;
						resp_status_q <= ST_RANGE;
					end
				end
				S_CHK: begin
					resp_status_q <= ST_USED;
					cnt_q         <= CNT_W'(1);
					idx_q         <= '0;
				end
				S_SCAN: begin
					if (take) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (state_d != S_SCAN) begin
						idx_q <= '0;
					end else if (scan_rd) begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				S_REL: begin
					resp_status_q <= ST_NOSPACE;
					if (rel_rd) begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				S_OWR: begin
					if (out_load) begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Bitmap RAM: one write, one registered read
	always_ff @(posedge clk) begin
		if (u_wr_en) begin
			used_mem[u_wr_addr] <= u_wr_data;
		end
		if (u_rd_en) begin
			u_rdata_s1 <= used_mem[u_rd_addr];
		end
	end

	// Valid bits: an unwritten entry reads as free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uvld_q    <= '0;
			u_rvld_s1 <= 1'b0;
		end else begin
			if (u_wr_en) begin
				uvld_q[u_wr_addr] <= 1'b1;
			end
			if (u_rd_en) begin
				u_rvld_s1 <= uvld_q[u_rd_addr];
			end
		end
	end

	// Held-list RAM
	always_ff @(posedge clk) begin
		if (h_wr_en) begin
			held_mem[h_wr_addr] <= h_wr_data;
		end
		if (h_rd_en) begin
			hdata_s1 <= held_mem[h_rd_addr];
		end
	end

	// Output register: load when free, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_idx_q    <= out_idx;
			res_status_q <= out_status;
			res_last_q   <= out_last;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.block_index = res_idx_q;
	assign res.status      = res_status_q;
	assign res.last_of_run = res_last_q;

	`BBA_ASSERT_IMP(a_scan_cnt, state_q == S_SCAN, cnt_q <= want_q || cnt_q == CNT_W'(1), "held count passed the request length")
	`BBA_ASSERT_IMP(a_scan_idx, state_q == S_SCAN, idx_q <= n_eff, "scan ran beyond the block count")
	`BBA_ASSERT_IMP(a_rel_clear, state_q == S_REL && u_wr_en, !u_wr_data, "release pass marked a block used")
	`BBA_ASSERT_IMP(a_out_load, out_load, !res_valid_q || res.ready, "pending result overwritten")
	`BBA_ASSERT_NXT(a_chk_scan, state_q == S_CHK && !used_s1, state_q == S_SCAN && cnt_q == CNT_W'(1), "scan did not start with the start block held")

endmodule

// ===== dv/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bba_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 8_000_000;
	localparam int unsigned DRAIN_CYCLES = 2 * MAX_BLOCKS + MAX_BLOCKS + 16;
	localparam int unsigned ITEMS_PER_PHASE = 48;
	localparam int unsigned PHASES = 9;

	typedef struct packed {
		logic [IDX_W-1:0] block_index;
		status_t          status;
		logic             last_of_run;
	} alloc_result_t;

	typedef enum logic {
		ROW_REQUEST,
		ROW_SETTING
	} row_kind_t;

	// value is the start block for a request, the block count for a setting
	typedef struct packed {
		row_kind_t     kind;
		logic [6:0]    value;
		logic [6:0]    length;
		logic          typed;
		alloc_result_t known;
	} plan_row_t;

	localparam alloc_result_t NO_RESULT = '{6'd0, ST_OK, 1'b0};
	localparam int unsigned PLAN_ROWS = 22;

	// Directed plan, from reset with 64 blocks managed
	localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
		'{ROW_REQUEST, 7'd5,   7'd0,   1'b1, '{6'd5,  ST_OK,      1'b1}},
		'{ROW_REQUEST, 7'd5,   7'd1,   1'b1, '{6'd5,  ST_USED,    1'b1}},
		'{ROW_REQUEST, 7'd63,  7'd1,   1'b1, '{6'd63, ST_OK,      1'b1}},
		'{ROW_REQUEST, 7'd0,   7'd64,  1'b1, '{6'd0,  ST_NOSPACE, 1'b1}},
		'{ROW_REQUEST, 7'd0,   7'd3,   1'b0, NO_RESULT},
		'{ROW_REQUEST, 7'd62,  7'd127, 1'b1, '{6'd62, ST_NOSPACE, 1'b1}},
		'{ROW_REQUEST, 7'd30,  7'd2,   1'b0, NO_RESULT},
		'{ROW_REQUEST, 7'd40,  7'd64,  1'b0, NO_RESULT},
		'{ROW_SETTING, 7'd0,   7'd0,   1'b0, NO_RESULT},
		'{ROW_REQUEST, 7'd0,   7'd1,   1'b1, '{6'd0,  ST_RANGE,   1'b1}},
		'{ROW_REQUEST, 7'd63,  7'd127, 1'b1, '{6'd63, ST_RANGE,   1'b1}},
		'{ROW_SETTING, 7'd127, 7'd0,   1'b0, NO_RESULT},
		'{ROW_REQUEST, 7'd63,  7'd1,   1'b1, '{6'd63, ST_USED,    1'b1}},
		'{ROW_REQUEST, 7'd10,  7'd5,   1'b0, NO_RESULT},
		'{ROW_SETTING, 7'd1,   7'd0,   1'b0, NO_RESULT},
		'{ROW_REQUEST, 7'd1,   7'd1,   1'b1, '{6'd1,  ST_RANGE,   1'b1}},
		'{ROW_REQUEST, 7'd0,   7'd2,   1'b1, '{6'd0,  ST_USED,    1'b1}},
		'{ROW_SETTING, 7'd4,   7'd0,   1'b0, NO_RESULT},
		'{ROW_REQUEST, 7'd3,   7'd2,   1'b1, '{6'd3,  ST_USED,    1'b1}},
		'{ROW_SETTING, 7'd64,  7'd0,   1'b0, NO_RESULT},
		'{ROW_REQUEST, 7'd50,  7'd20,  1'b0, NO_RESULT},
		'{ROW_REQUEST, 7'd11,  7'd64,  1'b0, NO_RESULT}
	};

	// Block counts for the random phases; the last one is drawn at run time
	localparam logic [6:0] PHASE_COUNTS [PHASES] = '{
		7'd8, 7'd16, 7'd1, 7'd0, 7'd32, 7'd127, 7'd48, 7'd64, 7'd0
	};

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	bba_req_if req_ch ();
	bba_res_if res_ch ();

	bitmap_block_allocator uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow of the allocator state
	logic [MAX_BLOCKS-1:0] used_map;
	logic [CNT_W-1:0] managed_blocks;

	alloc_result_t pending_blocks [$];
	int unsigned mismatches;
	int unsigned requests_sent;
	int unsigned settings_written;
	int unsigned cycle_count;
	int unsigned seen_ok;
	int unsigned seen_used;
	int unsigned seen_nospace;
	int unsigned seen_range;
	bit calm;

	always #5 clk = ~clk;

	// Gap length: mostly none or short, now and then long
	function automatic int unsigned gap_length();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int unsigned effective_blocks();
		return (managed_blocks > MAX_BLOCKS) ? MAX_BLOCKS : managed_blocks;
	endfunction

	// First-fit allocation on the shadow bitmap; returns the blocks handed out
	function automatic void allocate_blocks(input logic [IDX_W-1:0] start,
			input logic [LEN_W-1:0] want, output alloc_result_t produced [$]);
		int unsigned limit;
		int unsigned held_count;
		logic [MAX_BLOCKS-1:0] taken;
		logic [IDX_W-1:0] held [$];
		limit = effective_blocks();
		produced.delete();
		if (start >= limit) begin
			produced.push_back('{start, ST_RANGE, 1'b1});
			return;
		end
		if (used_map[start]) begin
			produced.push_back('{start, ST_USED, 1'b1});
			return;
		end
		taken = '0;
		used_map[start] = 1'b1;
		taken[start] = 1'b1;
		held.push_back(start);
		held_count = 1;
		for (int unsigned b = 0; b < limit && held_count < want; b++) begin
			if (!used_map[b]) begin
				used_map[b] = 1'b1;
				taken[b] = 1'b1;
				held.push_back(IDX_W'(b));
				held_count++;
			end
		end
		// Give everything back when the scan runs dry
		if (held_count < want) begin
			used_map &= ~taken;
			produced.push_back('{start, ST_NOSPACE, 1'b1});
			return;
		end
		for (int unsigned k = 0; k < held_count; k++)
			produced.push_back('{held[k], ST_OK, (k + 1 == held_count)});
	endfunction

	// Offer one request, predict on acceptance and queue what is expected
	task automatic send_request(input logic [IDX_W-1:0] start, input logic [LEN_W-1:0] length,
			input logic typed, input alloc_result_t known);
		int unsigned gap;
		alloc_result_t produced [$];
		gap = gap_length();
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.first_block <= start;
		req_ch.file_length <= length;
		do @(posedge clk); while (!req_ch.ready);
		allocate_blocks(start, length, produced);
		if (typed)
			pending_blocks.push_back(known);
		else
			foreach (produced[k]) pending_blocks.push_back(produced[k]);
		requests_sent++;
	endtask

	// Drop valid and wait for the block to go quiet
	task automatic settle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		wait (pending_blocks.size() == 0);
	endtask

	// Write the block count over the configuration port, then read it back
	task automatic set_block_count(input logic [CNT_W-1:0] count);
		settle();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_BLOCKS_IN_USE, 2'b00};
		pwdata <= PDATA_W'(count);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		managed_blocks = count;
		settings_written++;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== PDATA_W'(count)) begin
			$display("%0t: block count read back: expected %0d, actual %0d",
				$time, count, prdata);
			mismatches++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Result side: stall at random, compare each item with the oldest expectation
	initial begin
		int unsigned stall;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = gap_length();
			if (stall > 0) begin
				@(negedge clk);
				res_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			res_ch.ready <= 1'b1;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_blocks.size() == 0) begin
				$display("%0t: unexpected item: block %0d status %s last %0b", $time,
					res_ch.block_index, res_ch.status.name(), res_ch.last_of_run);
				mismatches++;
			end else begin
				want = pending_blocks.pop_front();
				if (res_ch.block_index !== want.block_index) begin
					$display("%0t: block_index: expected %0d, actual %0d", $time,
						want.block_index, res_ch.block_index);
					mismatches++;
				end
				if (res_ch.status !== want.status) begin
					$display("%0t: status: expected %s, actual %s", $time,
						want.status.name(), res_ch.status.name());
					mismatches++;
				end
				if (res_ch.last_of_run !== want.last_of_run) begin
					$display("%0t: last_of_run: expected %0b, actual %0b", $time,
						want.last_of_run, res_ch.last_of_run);
					mismatches++;
				end
				case (want.status)
					ST_OK:      seen_ok++;
					ST_USED:    seen_used++;
					ST_NOSPACE: seen_nospace++;
					default:    seen_range++;
				endcase
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		int unsigned limit;
		int unsigned roll;
		logic [IDX_W-1:0] start;
		logic [LEN_W-1:0] length;
		logic [IDX_W-1:0] free_blocks [$];
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.first_block = '0;
		req_ch.file_length = '0;
		used_map = '0;
		managed_blocks = BLOCKS_RESET;
		mismatches = 0;
		requests_sent = 0;
		settings_written = 0;
		cycle_count = 0;
		seen_ok = 0;
		seen_used = 0;
		seen_nospace = 0;
		seen_range = 0;
		calm = 1'b0;

		// Hold reset, then release it on a falling clock edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed plan
		foreach (DIRECTED_PLAN[r]) begin
			if (DIRECTED_PLAN[r].kind == ROW_SETTING)
				set_block_count(DIRECTED_PLAN[r].value);
			else
				send_request(IDX_W'(DIRECTED_PLAN[r].value), DIRECTED_PLAN[r].length,
					DIRECTED_PLAN[r].typed, DIRECTED_PLAN[r].known);
		end

		// Random phases, each under its own block count
		for (int unsigned ph = 0; ph < PHASES; ph++) begin
			set_block_count((ph == PHASES - 1) ? CNT_W'($urandom_range(0, 127))
				: PHASE_COUNTS[ph]);
			calm = ($urandom_range(0, 3) == 0);
			for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
				limit = effective_blocks();
				free_blocks.delete();
				for (int unsigned b = 0; b < limit; b++)
					if (!used_map[b])
						free_blocks.push_back(IDX_W'(b));
				// Aim mostly at free blocks so that requests get past the checks
				roll = $urandom_range(0, 99);
				if (roll < 60 && free_blocks.size() > 0)
					start = free_blocks[$urandom_range(0, free_blocks.size() - 1)];
				else if (roll < 85 && limit > 0)
					start = IDX_W'($urandom_range(0, limit - 1));
				else
					start = IDX_W'($urandom_range(0, 63));
				roll = $urandom_range(0, 99);
				if (roll < 55)
					length = LEN_W'($urandom_range(0, 3));
				else if (roll < 80)
					length = LEN_W'($urandom_range(4, 12));
				else if (roll < 93)
					length = LEN_W'($urandom_range(13, 64));
				else
					length = LEN_W'($urandom_range(65, 127));
				send_request(start, length, 1'b0, NO_RESULT);
			end
		end

		// Drain and let the block fall idle
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("testbench: %0d requests under %0d block-count settings", requests_sent,
			settings_written);
		$display("testbench: %0d blocks handed out, %0d start used, %0d no space, %0d out of range",
			seen_ok, seen_used, seen_nospace, seen_range);
		if (mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
